/* rtl/bbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor package
// Shared widths, counter codes, control and status bundles, slot masking.
// ----------------------------------------------------------------------------
package bbp_pkg;

	localparam int IDX_W   = 12;
	localparam int DEPTH   = 1 << IDX_W;
	localparam int PC_W    = 32;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 4;
	localparam int CTR_W   = 2;

	localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'd0;
	localparam logic [CTR_W-1:0] CTR_WEAK_T    = 2'd2;
	localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'd3;

	localparam logic [CFG_W-1:0] IDX_BITS_RST  = CFG_W'(IDX_W);

	// Controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic load;
		logic exec;
	} bbp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
	} bbp_sts_t;

	// Clamp the index width to 1..IDX_W and build the slot mask.
	function automatic logic [IDX_W-1:0] slot_mask(input logic [CFG_W-1:0] bits);
		logic [CFG_W-1:0] eff;
		logic [IDX_W-1:0] m;
		eff = bits;
		if (eff < CFG_W'(1)) begin
			eff = CFG_W'(1);
		end
		if (eff > CFG_W'(IDX_W)) begin
			eff = CFG_W'(IDX_W);
		end
		for (int i = 0; i < IDX_W; i++) begin
			m[i] = (i < int'(eff));
		end
		return m;
	endfunction

endpackage

/* rtl/bbp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor controller
// Sequences the table clearing sweep, branch acceptance and counter update.
// ----------------------------------------------------------------------------
module bbp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bbp_pkg::bbp_sts_t  sts,
	output bbp_pkg::bbp_cmd_t  cmd,
	output logic               busy
);
	import bbp_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.exec     = (state_q == ST_EXEC);
	end

	assign busy = busy_q;

endmodule

/* rtl/bbp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor datapath
// Counter table, index width register, miss counter and result registers.
// ----------------------------------------------------------------------------
module bbp_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbp_pkg::bbp_cmd_t             cmd,
	output bbp_pkg::bbp_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [bbp_pkg::CFG_W-1:0]     cfg_data,
	input  logic [bbp_pkg::PC_W-1:0]      pc,
	input  logic                          taken,
	output logic                          done,
	output logic                          predicted_taken,
	output logic                          mispredicted,
	output logic [bbp_pkg::CNT_W-1:0]     miss_total,
	output logic                          rejected
);
	import bbp_pkg::*;

	logic [CTR_W-1:0] table_mem [DEPTH];

	logic [IDX_W-1:0] clr_addr_q;
	logic [CFG_W-1:0] index_bits_q;
	logic [CNT_W-1:0] miss_q;

	logic [IDX_W-1:0] slot_q;
	logic             taken_q;
	logic             zero_q;
	logic [CTR_W-1:0] rd_q;

	logic             done_q;
	logic             pred_q;
	logic             mis_q;
	logic [CNT_W-1:0] total_q;
	logic             rej_q;

	logic [IDX_W-1:0] slot_d;
	logic             guess;
	logic             miss;
	logic [CTR_W-1:0] ctr_nxt;
	logic [CNT_W-1:0] miss_nxt;

	assign slot_d   = pc[IDX_W+1:2] & slot_mask(index_bits_q);
	assign guess    = rd_q[1];
	assign miss     = guess ^ taken_q;
	assign sts.clr_last = &clr_addr_q;

	always_comb begin
		ctr_nxt = rd_q;
		if (taken_q) begin
			if (rd_q != CTR_STRONG_T) begin
				ctr_nxt = rd_q + CTR_W'(1);
			end
		end else begin
			if (rd_q != CTR_STRONG_NT) begin
				ctr_nxt = rd_q - CTR_W'(1);
			end
		end
		miss_nxt = miss_q;
		if (!zero_q && miss && (miss_q != '1)) begin
			miss_nxt = miss_q + CNT_W'(1);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			index_bits_q <= IDX_BITS_RST;
			miss_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
			if (cfg_we) begin
				index_bits_q <= cfg_data;
			end
			if (cmd.exec) begin
				miss_q <= miss_nxt;
			end
			done_q <= cmd.exec;
		end
	end

	// Counter table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			table_mem[clr_addr_q] <= CTR_WEAK_T;
		end else if (cmd.exec && !zero_q) begin
			table_mem[slot_q] <= ctr_nxt;
		end
		if (cmd.load) begin
			rd_q <= table_mem[slot_d];
		end
	end

	// Capture the branch and present the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q  <= slot_d;
			taken_q <= taken;
			zero_q  <= (pc == '0);
		end
		if (cmd.exec) begin
			pred_q  <= zero_q ? 1'b0 : guess;
			mis_q   <= zero_q ? 1'b0 : miss;
			total_q <= miss_nxt;
			rej_q   <= zero_q;
		end
	end

	assign done            = done_q;
	assign predicted_taken = pred_q;
	assign mispredicted    = mis_q;
	assign miss_total      = total_q;
	assign rejected        = rej_q;

endmodule

/* rtl/bimodal_branch_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor
// Table of 2-bit saturating counters trained by resolved branches.
// ----------------------------------------------------------------------------
// Usage:
//   Branch channel: drive pc and taken with start high; the beat is taken at
//   an edge where busy is low. Each beat yields exactly one result beat.
//   Result channel: done is high for one cycle with predicted_taken,
//   mispredicted, miss_total and rejected; the receiver cannot stall it, so
//   capture it in that cycle. The result fields hold until the next result.
//   Timing: the accepting edge registers the table read and the update state
//   registers the result. A new branch waits for the last: the counter table
//   read is registered, and the update writes back before the next read.
//   A pc of zero is flagged rejected and leaves the table and miss count alone.
//   Configuration: cfg_valid/cfg_data write index_bits (always ready); only
//   write while no branch is in flight. Values are clamped to 1..12 on use.
//   Reset: arst_n clears the miss count and index_bits goes to 12. A sweep
//   then sets every one of the 4096 counters to weakly taken; busy stays high
//   throughout, while configuration writes are still accepted.
// ----------------------------------------------------------------------------
module bimodal_branch_predictor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [bbp_pkg::PC_W-1:0]   pc,
	input  logic                       taken,
	output logic                       done,
	output logic                       predicted_taken,
	output logic                       mispredicted,
	output logic [bbp_pkg::CNT_W-1:0]  miss_total,
	output logic                       rejected,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bbp_pkg::CFG_W-1:0]  cfg_data
);
	import bbp_pkg::*;

	bbp_cmd_t cmd;
	bbp_sts_t sts;

	// Register write is a single flop update, so never hold the beat off
	assign cfg_ready = 1'b1;

	bbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bbp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.pc              (pc),
		.taken           (taken),
		.done            (done),
		.predicted_taken (predicted_taken),
		.mispredicted    (mispredicted),
		.miss_total      (miss_total),
		.rejected        (rejected)
	);

`ifndef SYNTHESIS
	// An accepted beat keeps the block busy, then it reports as busy drops
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done) ##1 (done && !busy))
		else $error("result beat did not follow accepted branch");

	// Results only come from the update cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a branch in flight");

	// A rejected branch never reports a prediction or a miss
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rejected) |-> (!predicted_taken && !mispredicted))
		else $error("rejected branch reported a prediction");
`endif

endmodule
